@@ hw/rtl/blm_pkg.sv @@
// Shared types and constants for the battery level monitor.
// No dependencies; imported by every module of the block.
package blm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TEMP_W   = 8;
  localparam int SEG_W    = 3;
  localparam int CHG_W    = 4;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int CFG_W    = 16;

  // Register indexes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    CFG_SEG_ONE   = 2'd0,
    CFG_SEG_TWO   = 2'd1,
    CFG_SEG_THREE = 2'd2,
    CFG_ALARM     = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] SEG_ONE_RST   = 16'd3000;
  localparam logic [CFG_W-1:0] SEG_TWO_RST   = 16'd3400;
  localparam logic [CFG_W-1:0] SEG_THREE_RST = 16'd3800;
  localparam logic [CFG_W-1:0] ALARM_RST     = 16'd3000;

  // Temperature correction: 7.5 mV per degree below the reference
  localparam logic signed [11:0]       TEMP_REF  = 12'sd20;
  localparam logic signed [11:0]       TEMP_SLOPE = 12'sd15;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -8'sd40;

  localparam logic [SEG_W-1:0] SEG_1 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_3 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_4 = 3'd4;

  localparam logic [CHG_W-1:0] CHG_EXT_POWER   = 4'b0001;
  localparam logic [CHG_W-1:0] CHG_CHARGING    = 4'b0010;
  localparam logic [CHG_W-1:0] CHG_NOT_CHARGING = 4'b0100;
  localparam logic [CHG_W-1:0] CHG_DISCHARGING = 4'b1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/blm_ring.sv @@
// Sample ring: one synchronous RAM with a registered read port, plus the
// write slot and fill count. Depends on blm_pkg.
module blm_ring
  import blm_pkg::*;
#(
  parameter int DEPTH  = 50,
  parameter int SLOT_W = 6,
  parameter int CNT_W  = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic [SLOT_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data,
  output logic [CNT_W-1:0]    fill
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;

  // Entries at or above the fill count were never written and are not summed
  // by the walker, so the RAM itself needs no clearing.
  always_comb begin
    slot_nxt = slot_r;
    fill_nxt = fill_r;
    if (wr_en) begin
      slot_nxt = (slot_r == SLOT_W'(DEPTH - 1)) ? '0 : slot_r + 1'b1;
      if (fill_r != CNT_W'(DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
    end else begin
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign fill    = fill_r;

endmodule

@@ hw/rtl/blm_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on blm_pkg only through the shared import style.
module blm_div
  import blm_pkg::*;
#(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DIVIDEND_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? DIVISOR_W'(shifted - {1'b0, divisor}) : shifted[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/battery_level_monitor.sv @@
// Battery level monitor top: config registers, temperature correction,
// ring walk and result formatting. Depends on blm_pkg, blm_ring, blm_div.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+---------------------------
//   in      | in_valid/in_stall + four payload ports  | one battery sample item
//   out     | out_valid/out_stall + four result ports | one averaged status item
//   cfg     | psel penable pwrite paddr pwdata prdata | four 16-bit limit registers
//
// An item goes from accept to result through a write, a walk at one RAM read per cycle,
// a divide at one bit per cycle and a load; a zero entry ends the walk early.
// The next item can be taken in the cycle after the result is loaded.
// Reset clears the write slot and fill count; unwritten entries are never summed by the walk.
// in_stall is high while an item is in flight; a result held by out_stall does not
// block the next item until that item's own result is ready.
module battery_level_monitor
  import blm_pkg::*;
#(
  parameter int RING_DEPTH = 50
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_W-1:0]        in_sample_mv,
  input  logic signed [TEMP_W-1:0]   in_temperature_c,
  input  logic                       in_ext_power_pin,
  input  logic                       in_charge_pin,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [SAMPLE_W-1:0]        out_average_mv,
  output logic [SEG_W-1:0]           out_capacity_segment,
  output logic                       out_low_alarm,
  output logic [CHG_W-1:0]           out_charger_state,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_AW-1:0]          paddr,
  input  logic [CFG_DW-1:0]          pwdata,
  output logic [CFG_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] seg_one_r, seg_two_r, seg_three_r, alarm_lim_r;
  logic             cfg_wr;
  cfg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_one_r   <= SEG_ONE_RST;
      seg_two_r   <= SEG_TWO_RST;
      seg_three_r <= SEG_THREE_RST;
      alarm_lim_r <= ALARM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_SEG_ONE:   seg_one_r   <= pwdata[CFG_W-1:0];
        CFG_SEG_TWO:   seg_two_r   <= pwdata[CFG_W-1:0];
        CFG_SEG_THREE: seg_three_r <= pwdata[CFG_W-1:0];
        CFG_ALARM:     alarm_lim_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_SEG_ONE:   prdata = CFG_DW'(seg_one_r);
      CFG_SEG_TWO:   prdata = CFG_DW'(seg_two_r);
      CFG_SEG_THREE: prdata = CFG_DW'(seg_three_r);
      CFG_ALARM:     prdata = CFG_DW'(alarm_lim_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------- temperature correction ----------------
  logic signed [11:0] diff_s, prod_s, offset_s;
  logic signed [17:0] comp_s;
  logic [SAMPLE_W-1:0] comp_sat;

  always_comb begin
    diff_s = TEMP_REF - 12'(in_temperature_c);
    prod_s = diff_s * TEMP_SLOPE;
    // halve toward zero; below TEMP_MIN no correction is applied
    if (in_temperature_c < TEMP_MIN) begin
      offset_s = '0;
    end else if (prod_s[11]) begin
      offset_s = -((-prod_s) >>> 1);
    end else begin
      offset_s = prod_s >>> 1;
    end
    comp_s = $signed({2'b00, in_sample_mv}) - 18'(offset_s);
    if (comp_s[17]) begin
      comp_sat = '0;
    end else if (comp_s[16]) begin
      comp_sat = '1;
    end else begin
      comp_sat = comp_s[SAMPLE_W-1:0];
    end
  end

  // ---------------- control ----------------
  state_t              state_r, state_nxt;
  logic [SAMPLE_W-1:0] comp_r, comp_nxt;
  logic                ext_r, ext_nxt;
  logic                chg_pin_r, chg_pin_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [SUM_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                in_acc;
  logic                ring_wr;
  logic                div_start;
  logic                out_load;
  logic [SAMPLE_W-1:0] rd_data;
  logic [CNT_W-1:0]    fill;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic [SAMPLE_W-1:0] avg;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    comp_nxt    = comp_r;
    ext_nxt     = ext_r;
    chg_pin_nxt = chg_pin_r;
    rd_idx_nxt  = rd_idx_r;
    pend_nxt    = 1'b0;
    total_nxt   = total_r;
    count_nxt   = count_r;
    ring_wr     = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          comp_nxt    = comp_sat;
          ext_nxt     = in_ext_power_pin;
          chg_pin_nxt = in_charge_pin;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ring_wr    = 1'b1;
        rd_idx_nxt = '0;
        total_nxt  = '0;
        count_nxt  = '0;
        state_nxt  = ST_WALK;
      end
      ST_WALK: begin
        // issue reads in order; returning data belongs to entry count_r
        if (rd_idx_r < CNT_W'(RING_DEPTH)) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (count_r >= fill || (pend_r && rd_data == '0)) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (pend_r) begin
          total_nxt = total_r + SUM_W'(rd_data);
          count_nxt = count_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the previous result has been taken
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    comp_r    <= comp_nxt;
    ext_r     <= ext_nxt;
    chg_pin_r <= chg_pin_nxt;
    rd_idx_r  <= rd_idx_nxt;
    total_r   <= total_nxt;
    count_r   <= count_nxt;
  end

  blm_ring #(
    .DEPTH  (RING_DEPTH),
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ring_wr),
    .wr_data (comp_r),
    .rd_addr (rd_idx_r[SLOT_W-1:0]),
    .rd_data (rd_data),
    .fill    (fill)
  );

  blm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- result ----------------
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] avg_out_r;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic                alarm_r;
  logic [CHG_W-1:0]    chg_state_r, chg_state_nxt;

  assign avg = (count_r == '0) ? '0 : quotient[SAMPLE_W-1:0];

  always_comb begin
    if (avg > seg_three_r) begin
      seg_nxt = SEG_4;
    end else if (avg > seg_two_r) begin
      seg_nxt = SEG_3;
    end else if (avg > seg_one_r) begin
      seg_nxt = SEG_2;
    end else begin
      seg_nxt = SEG_1;
    end
    chg_state_nxt = (ext_r ? CHG_DISCHARGING : CHG_EXT_POWER)
                  | (chg_pin_r ? CHG_NOT_CHARGING : CHG_CHARGING);
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_out_r   <= avg;
      seg_r       <= seg_nxt;
      alarm_r     <= ext_r && (avg <= alarm_lim_r);
      chg_state_r <= chg_state_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_average_mv       = avg_out_r;
  assign out_capacity_segment = seg_r;
  assign out_low_alarm        = alarm_r;
  assign out_charger_state    = chg_state_r;

  // ---------------- assertions ----------------
  a_count_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (count_r <= fill))
    else $error("walk counted past the filled entries");

  a_fill_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= CNT_W'(RING_DEPTH))
    else $error("ring fill count beyond depth");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (seg_r == SEG_1 || seg_r == SEG_2 || seg_r == SEG_3 || seg_r == SEG_4))
    else $error("capacity segment out of range");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

endmodule
